// File: sv/toy_cpu_execute_unit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the execute unit checker.
// ----------------------------------------------------------------------------
`ifndef TOY_CPU_EXECUTE_UNIT_CORE_MACROS_SVH
`define TOY_CPU_EXECUTE_UNIT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCEU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tceu_pkg.sv
// ----------------------------------------------------------------------------
// tceu_pkg
// Types and constants shared by the execute unit, its channels and checker.
// ----------------------------------------------------------------------------
package tceu_pkg;

   // Operation codes.
   localparam logic [3:0] OP_LOAD    = 4'd0;
   localparam logic [3:0] OP_STORE   = 4'd1;
   localparam logic [3:0] OP_PUSH    = 4'd2;
   localparam logic [3:0] OP_POP_REG = 4'd3;
   localparam logic [3:0] OP_POP_VAL = 4'd4;
   localparam logic [3:0] OP_MOV     = 4'd5;
   localparam logic [3:0] OP_ADD     = 4'd6;
   localparam logic [3:0] OP_SUB     = 4'd7;
   localparam logic [3:0] OP_MUL     = 4'd8;
   localparam logic [3:0] OP_DIV     = 4'd9;
   localparam logic [3:0] OP_REM     = 4'd10;
   localparam logic [3:0] OP_AND     = 4'd11;
   localparam logic [3:0] OP_OR      = 4'd12;

   // Error codes.
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_DIV   = 2'd1;
   localparam logic [1:0] ERR_ADDR  = 2'd2;
   localparam logic [1:0] ERR_STACK = 2'd3;

   // Bytes in one word access.
   localparam int WORD_BYTES = 4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_EXEC,
      ST_MEM,
      ST_DIV,
      ST_DIV_FIX,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg1;
      logic [4:0]         src_reg2;
      logic signed [31:0] immediate;
      logic               use_register;
   } req_item_type;

   typedef struct packed {
      logic               wrote_reg;
      logic [4:0]         write_index;
      logic signed [31:0] result_value;
      logic [1:0]         error_code;
      logic [31:0]        read_marks;
      logic [31:0]        write_marks;
      logic [15:0]        region_marks;
      logic               stack_touched;
   } rsp_item_type;

   // Divider start request.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_ctrl_type;

   // Divider status.
   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [31:0] remainder;
   } div_stat_type;

endpackage

// File: sv/tceu_if.sv
// ----------------------------------------------------------------------------
// tceu_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface tceu_req_if import tceu_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tceu_rsp_if import tceu_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/toy_cpu_execute_unit_core.sv
// Execute unit for a small load/store machine. Each instruction beat runs to
// completion before the next is taken: two register file reads (one read
// port), the execute state, then either byte-wise memory or stack access,
// the one-bit-per-cycle divider for a successful div or rem, or straight to
// the result. After reset the data and stack memories are swept to zero,
// one byte a cycle, across the larger of MEM_BYTES and STACK_BYTES; no beat
// is taken until then, though the stack base register may be written.
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_core
// Register file, data memory and stack held in RAMs, sequenced per beat.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_core import tceu_pkg::*; #(
   parameter int MEM_BYTES    = 65536,
   parameter int STACK_BYTES  = 4096,
   parameter int REGION_COUNT = 16,
   parameter int REG_COUNT    = 32
) (
   input  logic        clock,
   input  logic        reset,
   tceu_req_if.sink    req_bus,
   tceu_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   localparam int RIW         = $clog2(REG_COUNT);
   localparam int MAW         = $clog2(MEM_BYTES);
   localparam int SAW         = $clog2(STACK_BYTES);
   localparam int REGION_SIZE = MEM_BYTES / REGION_COUNT;
   localparam int CLR_DEPTH   = (MEM_BYTES > STACK_BYTES) ? MEM_BYTES : STACK_BYTES;
   localparam int CLW         = $clog2(CLR_DEPTH);

   state_type state_ff, state_in;

   req_item_type item_ff;
   logic [RIW-1:0] rd_ff, r1_ff, r2_ff;
   logic [RIW-1:0] wrap_tab [32];

   logic [31:0] a_ff, b_ff, val_ff;
   logic [1:0]  err_ff;
   logic [2:0]  cnt_ff;
   logic [15:0] touch_ff;
   logic [CLW-1:0] clr_ff;

   logic [12:0] base_ff, sp_ff;
   logic [31:0] read_marks_ff, write_marks_ff;
   logic [15:0] region_ff;
   logic        stack_flag_ff;

   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_free;

   // Register file signals.
   logic [REG_COUNT-1:0] rf_valid_ff;
   logic [RIW-1:0]       rf_raddr, rf_raddr_ff;
   logic [31:0]          rf_rdata, rf_rdata_masked;
   logic                 rf_we;

   // Byte memory signals.
   logic           dm_we, sm_we;
   logic [MAW-1:0] dm_addr;
   logic [SAW-1:0] sm_addr;
   logic [7:0]     dm_wdata, sm_wdata, dm_rdata, sm_rdata, byte_out;

   logic [31:0] opb, exec_val, div_fix_val;
   logic [1:0]  exec_err;
   logic        addr_ok, push_ok, pop_ok;
   logic        is_load, is_store, is_push, is_pop, is_alu, is_div;
   logic        wrote_c;
   logic [31:0] read_mask, write_mask;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   // Register indices wrap modulo the register count.
   for (genvar g = 0; g < 32; g++) begin : g_wrap
      assign wrap_tab[g] = RIW'(g % REG_COUNT);
   end

   // Region of one byte address: largest boundary it reaches.
   function automatic logic [15:0] region_bit(input logic [MAW-1:0] addr);
      logic [3:0] idx;
      idx = '0;
      for (int k = 1; k < REGION_COUNT; k++) begin
         if (32'(addr) >= 32'(k * REGION_SIZE)) begin
            idx = 4'(k);
         end
      end
      return 16'(1) << idx;
   endfunction

   // Operation groups.
   assign is_load  = item_ff.operation == OP_LOAD;
   assign is_store = item_ff.operation == OP_STORE;
   assign is_push  = item_ff.operation == OP_PUSH;
   assign is_pop   = (item_ff.operation == OP_POP_REG) || (item_ff.operation == OP_POP_VAL);
   assign is_div   = (item_ff.operation == OP_DIV) || (item_ff.operation == OP_REM);
   assign is_alu   = (item_ff.operation >= OP_ADD) && (item_ff.operation <= OP_OR);

   // Execute-stage checks and values.
   assign opb     = item_ff.use_register ? b_ff : $unsigned(item_ff.immediate);
   assign addr_ok = ({1'b0, a_ff} + 33'd3) < 33'(MEM_BYTES);
   assign push_ok = (sp_ff >= 13'(WORD_BYTES)) && (32'(sp_ff) <= 32'(STACK_BYTES));
   assign pop_ok  = ((14'(sp_ff) + 14'(WORD_BYTES)) <= 14'(base_ff))
                 && ((32'(sp_ff) + 32'(WORD_BYTES)) <= 32'(STACK_BYTES));

   always_comb begin
      exec_err = ERR_NONE;
      if ((is_load || is_store) && !addr_ok) begin
         exec_err = ERR_ADDR;
      end else if (is_push && !push_ok) begin
         exec_err = ERR_STACK;
      end else if (is_pop && !pop_ok) begin
         exec_err = ERR_STACK;
      end else if (is_div && (opb == 32'd0)) begin
         exec_err = ERR_DIV;
      end
   end

   always_comb begin
      unique case (item_ff.operation)
         OP_STORE:        exec_val = b_ff;
         OP_PUSH, OP_MOV: exec_val = item_ff.use_register ? a_ff : opb;
         OP_ADD:          exec_val = a_ff + opb;
         OP_SUB:          exec_val = a_ff - opb;
         OP_MUL:          exec_val = a_ff * opb;
         OP_AND:          exec_val = a_ff & opb;
         OP_OR:           exec_val = a_ff | opb;
         default:         exec_val = '0;
      endcase
   end

   // Sign correction of the divider result.
   always_comb begin
      if (item_ff.operation == OP_DIV) begin
         div_fix_val = (a_ff[31] != opb[31]) ? (32'd0 - div_stat.quotient)
                                             : div_stat.quotient;
      end else begin
         div_fix_val = a_ff[31] ? (32'd0 - div_stat.remainder) : div_stat.remainder;
      end
   end

   assign div_ctrl.start    = (state_ff == ST_EXEC) && is_div && (exec_err == ERR_NONE);
   assign div_ctrl.dividend = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign div_ctrl.divisor  = opb[31] ? (32'd0 - opb) : opb;

   tceu_divider u_tceu_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // Commit decisions for the finishing beat.
   assign wrote_c = (err_ff == ERR_NONE)
                 && (is_load || is_alu || (item_ff.operation == OP_POP_REG)
                     || (item_ff.operation == OP_MOV));

   always_comb begin
      read_mask  = '0;
      write_mask = '0;
      if (err_ff == ERR_NONE) begin
         if (is_load || is_alu) begin
            read_mask = read_mask | (32'(1) << r1_ff);
         end
         if (is_store) begin
            read_mask = read_mask | (32'(1) << r1_ff) | (32'(1) << rd_ff);
         end
         if ((is_push || (item_ff.operation == OP_MOV)) && item_ff.use_register) begin
            read_mask = read_mask | (32'(1) << r1_ff);
         end
         if (is_alu && item_ff.use_register) begin
            read_mask = read_mask | (32'(1) << r2_ff);
         end
         if (wrote_c) begin
            write_mask = 32'(1) << rd_ff;
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == CLW'(CLR_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:    if (req_bus.valid) state_in = ST_READ_A;
         ST_READ_A:  state_in = ST_READ_B;
         ST_READ_B:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_err != ERR_NONE) begin
               state_in = ST_FINISH;
            end else if (is_load || is_store || is_push || is_pop) begin
               state_in = ST_MEM;
            end else if (is_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MEM:     if (cnt_ff == 3'd4) state_in = ST_FINISH;
         ST_DIV:     if (div_stat.done) state_in = ST_DIV_FIX;
         ST_DIV_FIX: state_in = ST_FINISH;
         ST_FINISH:  if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: ports, addresses and write enables.
   always_comb begin
      req_bus.ready = state_ff == ST_IDLE;
      rf_we         = (state_ff == ST_FINISH) && rsp_free && wrote_c;
      byte_out      = val_ff[8 * cnt_ff[1:0] +: 8];

      unique case (state_ff)
         ST_IDLE:   rf_raddr = (req_bus.payload.operation == OP_STORE)
                             ? wrap_tab[req_bus.payload.dest_reg]
                             : wrap_tab[req_bus.payload.src_reg1];
         ST_READ_A: rf_raddr = is_store ? r1_ff : r2_ff;
         default:   rf_raddr = r1_ff;
      endcase

      dm_we    = 1'b0;
      sm_we    = 1'b0;
      dm_wdata = byte_out;
      sm_wdata = byte_out;
      dm_addr  = MAW'(a_ff) + MAW'(cnt_ff);
      if (is_push) begin
         sm_addr = SAW'(32'(sp_ff) - 32'd1 - 32'(cnt_ff));
      end else begin
         sm_addr = SAW'(32'(sp_ff) + 32'(cnt_ff));
      end

      if (state_ff == ST_CLEAR) begin
         dm_addr  = MAW'(clr_ff);
         sm_addr  = SAW'(clr_ff);
         dm_wdata = '0;
         sm_wdata = '0;
         dm_we    = 32'(clr_ff) < 32'(MEM_BYTES);
         sm_we    = 32'(clr_ff) < 32'(STACK_BYTES);
      end else if ((state_ff == ST_MEM) && (cnt_ff != 3'd4)) begin
         dm_we = is_store;
         sm_we = is_push;
      end
   end

   tceu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regfile (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rd_ff),
      .wr_data (val_ff),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   tceu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_data_mem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_addr),
      .wr_data (dm_wdata),
      .rd_addr (dm_addr),
      .rd_data (dm_rdata)
   );

   tceu_ram #(.WIDTH(8), .DEPTH(STACK_BYTES)) u_stack_mem (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_addr),
      .wr_data (sm_wdata),
      .rd_addr (sm_addr),
      .rd_data (sm_rdata)
   );

   // Registers never written read as zero.
   assign rf_rdata_masked = rf_valid_ff[rf_raddr_ff] ? rf_rdata : 32'd0;

   // Control state, architectural state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rf_valid_ff    <= '0;
         base_ff        <= 13'd4096;
         sp_ff          <= 13'd4096;
         read_marks_ff  <= '0;
         write_marks_ff <= '0;
         region_ff      <= '0;
         stack_flag_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + CLW'(1);
         end
         if (csr_we) begin
            base_ff <= csr_wdata;
            sp_ff   <= csr_wdata;
         end
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == ST_FINISH) && rsp_free) begin
            rsp_valid_ff   <= 1'b1;
            read_marks_ff  <= read_marks_ff | read_mask;
            write_marks_ff <= write_marks_ff | write_mask;
            if (rf_we) begin
               rf_valid_ff[rd_ff] <= 1'b1;
            end
            if (err_ff == ERR_NONE) begin
               if (is_load || is_store) begin
                  region_ff <= region_ff | touch_ff;
               end
               if (is_push) begin
                  sp_ff         <= sp_ff - 13'(WORD_BYTES);
                  stack_flag_ff <= 1'b1;
               end
               if (is_pop) begin
                  sp_ff         <= sp_ff + 13'(WORD_BYTES);
                  stack_flag_ff <= 1'b1;
               end
            end
         end
      end
   end

   // Result beat payload, with the marks as they stand after this step.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_ff.wrote_reg     <= wrote_c;
         rsp_ff.write_index   <= wrote_c ? 5'(rd_ff) : 5'd0;
         rsp_ff.result_value  <= (err_ff == ERR_NONE) ? val_ff : 32'd0;
         rsp_ff.error_code    <= err_ff;
         rsp_ff.read_marks    <= read_marks_ff | read_mask;
         rsp_ff.write_marks   <= write_marks_ff | write_mask;
         rsp_ff.region_marks  <= ((err_ff == ERR_NONE) && (is_load || is_store))
                               ? (region_ff | touch_ff) : region_ff;
         rsp_ff.stack_touched <= stack_flag_ff
                               || ((err_ff == ERR_NONE) && (is_push || is_pop));
      end
   end

   // Datapath registers of the beat in flight.
   always_ff @(posedge clock) begin
      rf_raddr_ff <= rf_raddr;
      unique case (state_ff)
         ST_IDLE: begin
            item_ff <= req_bus.payload;
            rd_ff   <= wrap_tab[req_bus.payload.dest_reg];
            r1_ff   <= wrap_tab[req_bus.payload.src_reg1];
            r2_ff   <= wrap_tab[req_bus.payload.src_reg2];
         end
         ST_READ_A: a_ff <= rf_rdata_masked;
         ST_READ_B: b_ff <= rf_rdata_masked;
         ST_EXEC: begin
            err_ff   <= exec_err;
            val_ff   <= exec_val;
            cnt_ff   <= '0;
            touch_ff <= '0;
         end
         ST_MEM: begin
            cnt_ff <= cnt_ff + 3'd1;
            if ((is_load || is_store) && (cnt_ff != 3'd4)) begin
               touch_ff <= touch_ff | region_bit(dm_addr);
            end
            if (cnt_ff != 3'd0) begin
               if (is_load) begin
                  val_ff[8 * 2'(cnt_ff - 3'd1) +: 8] <= dm_rdata;
               end else if (is_pop) begin
                  val_ff <= {val_ff[23:0], sm_rdata};
               end
            end
         end
         ST_DIV_FIX: val_ff <= div_fix_val;
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

endmodule

// File: sv/tceu_ram.sv
// ----------------------------------------------------------------------------
// tceu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tceu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: sv/tceu_divider.sv
// ----------------------------------------------------------------------------
// tceu_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tceu_divider import tceu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] divisor_ff;
   logic [32:0] shifted;
   logic [32:0] trial;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign shifted = {rem_ff, quo_ff[31]};
   assign trial   = shifted - {1'b0, divisor_ff};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Partial remainder and quotient.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff     <= '0;
         quo_ff     <= ctrl.dividend;
         divisor_ff <= ctrl.divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

// File: sv/tceu_checker.sv
// ----------------------------------------------------------------------------
// tceu_checker
// Port-level checks on result beats of the execute unit.
// ----------------------------------------------------------------------------
`include "toy_cpu_execute_unit_core_macros.svh"

module tceu_checker import tceu_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_payload
);

   // A stalled result beat holds.
   `TCEU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result beat changed")

   // A failed step writes nothing and reports zero.
   `TCEU_ASSERT_NOW(a_err_clean, clock, reset, rsp_valid && (rsp_payload.error_code != ERR_NONE), !rsp_payload.wrote_reg && (rsp_payload.result_value == 32'sd0), "error beat carries a write")

   // A register write is always reflected in the write marks.
   `TCEU_ASSERT_NOW(a_write_marked, clock, reset, rsp_valid && rsp_payload.wrote_reg, rsp_payload.write_marks[rsp_payload.write_index], "written register not marked")

   // Without a write the index reads zero.
   `TCEU_ASSERT_NOW(a_index_idle, clock, reset, rsp_valid && !rsp_payload.wrote_reg, rsp_payload.write_index == 5'd0, "index set without write")

endmodule

bind toy_cpu_execute_unit_core tceu_checker u_tceu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

// File: tb/toy_cpu_execute_unit_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Execute unit testbench
// Sends instruction beats through the request channel and checks every result
// beat against an in-bench model of the register file, data memory, stack and
// the cumulative marks. Directed corner cases come first, then random phases
// under several stack bases, with random idling on both channels.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_core_tb;
   import tceu_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [12:0] csr_wdata;

   tceu_req_if req_if ();
   tceu_rsp_if rsp_if ();

   toy_cpu_execute_unit_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Model state of the execute unit.
   logic [31:0] model_regs [32];
   logic [7:0]  model_mem [65536];
   logic [7:0]  model_stack [4096];
   int          model_sp;
   int          model_base;
   logic [31:0] model_rd_marks;
   logic [31:0] model_wr_marks;
   logic [15:0] model_region_marks;
   logic        model_stack_used;

   req_item_type pending_instrs [$];
   rsp_item_type expected_results [$];
   int           mismatches;
   int           send_gap_left;
   int           recv_hold_left;
   int           long_hold_req;
   bit           no_idle;

   // Clock, reset and known input levels from time zero.
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #25000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void clear_model();
      for (int i = 0; i < 32; i++) model_regs[i] = '0;
      for (int i = 0; i < 65536; i++) model_mem[i] = '0;
      for (int i = 0; i < 4096; i++) model_stack[i] = '0;
      model_base         = 4096;
      model_sp           = 4096;
      model_rd_marks     = '0;
      model_wr_marks     = '0;
      model_region_marks = '0;
      model_stack_used   = 1'b0;
   endfunction

   // Executes one instruction on the model and returns the result beat.
   function automatic rsp_item_type execute_instr(req_item_type it);
      rsp_item_type r;
      logic [31:0]  a;
      logic [31:0]  b;
      logic [31:0]  val;
      logic [31:0]  ma;
      logic [31:0]  mb;
      logic [31:0]  q;
      logic [31:0]  rm;
      logic [1:0]   err;
      logic         wrote;
      int           addr;
      r     = '0;
      val   = '0;
      err   = ERR_NONE;
      wrote = 1'b0;
      case (it.operation)
         OP_LOAD: begin
            addr = model_regs[it.src_reg1] + 0;
            if (model_regs[it.src_reg1] > 32'd65532) begin
               err = ERR_ADDR;
            end else begin
               for (int i = 0; i < WORD_BYTES; i++) begin
                  val[8*i +: 8] = model_mem[addr + i];
                  model_region_marks[(addr + i) / 4096] = 1'b1;
               end
               model_regs[it.dest_reg] = val;
               model_rd_marks[it.src_reg1] = 1'b1;
               model_wr_marks[it.dest_reg] = 1'b1;
               wrote = 1'b1;
            end
         end
         OP_STORE: begin
            addr = model_regs[it.dest_reg] + 0;
            if (model_regs[it.dest_reg] > 32'd65532) begin
               err = ERR_ADDR;
            end else begin
               val = model_regs[it.src_reg1];
               for (int i = 0; i < WORD_BYTES; i++) begin
                  model_mem[addr + i] = val[8*i +: 8];
                  model_region_marks[(addr + i) / 4096] = 1'b1;
               end
               model_rd_marks[it.dest_reg] = 1'b1;
               model_rd_marks[it.src_reg1] = 1'b1;
            end
         end
         OP_PUSH: begin
            if (model_sp < 4 || model_sp > 4096) begin
               err = ERR_STACK;
            end else begin
               val = it.use_register ? model_regs[it.src_reg1] : it.immediate;
               for (int i = 0; i < WORD_BYTES; i++)
                  model_stack[model_sp - 1 - i] = val[8*i +: 8];
               model_sp -= 4;
               model_stack_used = 1'b1;
               if (it.use_register) model_rd_marks[it.src_reg1] = 1'b1;
            end
         end
         OP_POP_REG, OP_POP_VAL: begin
            if (model_sp + 4 > model_base || model_sp + 4 > 4096) begin
               err = ERR_STACK;
            end else begin
               for (int i = 0; i < WORD_BYTES; i++)
                  val = {val[23:0], model_stack[model_sp + i]};
               model_sp += 4;
               model_stack_used = 1'b1;
               if (it.operation == OP_POP_REG) begin
                  model_regs[it.dest_reg] = val;
                  model_wr_marks[it.dest_reg] = 1'b1;
                  wrote = 1'b1;
               end
            end
         end
         OP_MOV: begin
            if (it.use_register) begin
               val = model_regs[it.src_reg1];
               model_rd_marks[it.src_reg1] = 1'b1;
            end else begin
               val = it.immediate;
            end
            model_regs[it.dest_reg] = val;
            model_wr_marks[it.dest_reg] = 1'b1;
            wrote = 1'b1;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR: begin
            a = model_regs[it.src_reg1];
            b = it.use_register ? model_regs[it.src_reg2] : it.immediate;
            if ((it.operation == OP_DIV || it.operation == OP_REM) && b == 0) begin
               err = ERR_DIV;
            end else begin
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q  = ma / mb;
               rm = ma % mb;
               case (it.operation)
                  OP_ADD: val = a + b;
                  OP_SUB: val = a - b;
                  OP_MUL: val = a * b;
                  OP_AND: val = a & b;
                  OP_OR:  val = a | b;
                  OP_DIV: val = (a[31] != b[31]) ? -q : q;
                  default: val = a[31] ? -rm : rm;
               endcase
               model_regs[it.dest_reg] = val;
               model_rd_marks[it.src_reg1] = 1'b1;
               if (it.use_register) model_rd_marks[it.src_reg2] = 1'b1;
               model_wr_marks[it.dest_reg] = 1'b1;
               wrote = 1'b1;
            end
         end
         default: ;
      endcase
      if (err != ERR_NONE) val = '0;
      r.wrote_reg     = wrote;
      r.write_index   = wrote ? it.dest_reg : 5'd0;
      r.result_value  = val;
      r.error_code    = err;
      r.read_marks    = model_rd_marks;
      r.write_marks   = model_wr_marks;
      r.region_marks  = model_region_marks;
      r.stack_touched = model_stack_used;
      return r;
   endfunction

   function automatic req_item_type make_instr(logic [3:0] op, int rd, int r1, int r2,
                                               logic [31:0] imm, bit use_reg);
      req_item_type it;
      it.operation    = op;
      it.dest_reg     = 5'(rd);
      it.src_reg1     = 5'(r1);
      it.src_reg2     = 5'(r2);
      it.immediate    = imm;
      it.use_register = use_reg;
      return it;
   endfunction

   function automatic int pick_reg();
      return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
   endfunction

   // Operand values biased towards usable addresses and arithmetic corners.
   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return $urandom_range(0, 65532);
      if (sel < 50) return $urandom_range(65528, 65540);
      if (sel < 58) return $urandom_range(0, 3);
      if (sel < 64) return 32'hFFFF_FFFF;
      if (sel < 70) return 32'h8000_0000;
      return $urandom();
   endfunction

   function automatic req_item_type random_instr();
      int          sel;
      logic [3:0]  op;
      sel = $urandom_range(0, 99);
      if (sel < 15)      op = OP_MOV;
      else if (sel < 28) op = OP_LOAD;
      else if (sel < 41) op = OP_STORE;
      else if (sel < 53) op = OP_PUSH;
      else if (sel < 59) op = OP_POP_REG;
      else if (sel < 64) op = OP_POP_VAL;
      else if (sel < 97) op = 4'($urandom_range(OP_ADD, OP_OR));
      else               op = 4'($urandom_range(13, 15));
      return make_instr(op, pick_reg(), pick_reg(), pick_reg(), pick_value(),
                        $urandom_range(0, 1));
   endfunction

   function automatic int pick_gap();
      int sel;
      if (no_idle) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
   endtask

   // Driver: offers pending instructions and models each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid  <= 1'b0;
         send_gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_results.push_back(execute_instr(req_if.payload));
         if (!req_if.valid || req_if.ready) begin
            if (send_gap_left > 0) begin
               req_if.valid  <= 1'b0;
               send_gap_left <= send_gap_left - 1;
            end else if (pending_instrs.size() > 0) begin
               req_if.payload <= pending_instrs.pop_front();
               req_if.valid   <= 1'b1;
               send_gap_left  <= pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure and a field-by-field check of each result beat.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      int           sel;
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         recv_hold_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected result beat", got.result_value, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.wrote_reg !== want.wrote_reg)
                  note_mismatch("wrote_reg", got.wrote_reg, want.wrote_reg);
               if (got.write_index !== want.write_index)
                  note_mismatch("write_index", got.write_index, want.write_index);
               if (got.result_value !== want.result_value)
                  note_mismatch("result_value", got.result_value, want.result_value);
               if (got.error_code !== want.error_code)
                  note_mismatch("error_code", got.error_code, want.error_code);
               if (got.read_marks !== want.read_marks)
                  note_mismatch("read_marks", got.read_marks, want.read_marks);
               if (got.write_marks !== want.write_marks)
                  note_mismatch("write_marks", got.write_marks, want.write_marks);
               if (got.region_marks !== want.region_marks)
                  note_mismatch("region_marks", got.region_marks, want.region_marks);
               if (got.stack_touched !== want.stack_touched)
                  note_mismatch("stack_touched", got.stack_touched, want.stack_touched);
            end
         end
         if (long_hold_req > 0) begin
            rsp_if.ready   <= 1'b0;
            recv_hold_left <= long_hold_req;
            long_hold_req  = 0;
         end else if (recv_hold_left > 0) begin
            rsp_if.ready   <= 1'b0;
            recv_hold_left <= recv_hold_left - 1;
         end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
         end else begin
            sel = $urandom_range(0, 99);
            rsp_if.ready <= (sel < 75);
            if (sel >= 97) recv_hold_left <= $urandom_range(10, 60);
         end
      end
   end

   task automatic write_stack_base(int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 13'(value);
      @(posedge clock);
      csr_we     <= 1'b0;
      model_base = value & 16'h1FFF;
      model_sp   = model_base;
   endtask

   // Waits until every sent beat has its result, then lets the block settle.
   task automatic wait_drained();
      wait (pending_instrs.size() == 0 && !req_if.valid && expected_results.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_instrs.push_back(random_instr());
   endtask

   // Stimulus sequence.
   initial begin
      mismatches    = 0;
      long_hold_req = 0;
      no_idle       = 1'b0;
      clear_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Small stack so that overflow and underflow are reached quickly.
      write_stack_base(16);
      pending_instrs.push_back(make_instr(OP_MOV, 1, 0, 0, 32'h7FFF_FFFF, 0));
      pending_instrs.push_back(make_instr(OP_MOV, 2, 0, 0, 32'h8000_0000, 0));
      pending_instrs.push_back(make_instr(OP_MOV, 3, 0, 0, 32'hFFFF_FFFF, 0));
      pending_instrs.push_back(make_instr(OP_ADD, 5, 1, 0, 32'd1, 0));
      pending_instrs.push_back(make_instr(OP_SUB, 6, 2, 1, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_MUL, 7, 1, 1, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_DIV, 8, 2, 3, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_REM, 9, 2, 3, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_DIV, 10, 1, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_REM, 10, 1, 4, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_AND, 11, 3, 0, 32'h0F0F_0F0F, 0));
      pending_instrs.push_back(make_instr(OP_OR, 12, 4, 0, 32'hF000_0001, 0));
      // Last whole word of memory, then one byte past it.
      pending_instrs.push_back(make_instr(OP_MOV, 13, 0, 0, 32'd65532, 0));
      pending_instrs.push_back(make_instr(OP_STORE, 13, 1, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_LOAD, 14, 13, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_MOV, 15, 0, 0, 32'd65533, 0));
      pending_instrs.push_back(make_instr(OP_LOAD, 16, 15, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_STORE, 15, 2, 0, 32'd0, 0));
      // Fill the stack, overflow it, then drain it and underflow.
      pending_instrs.push_back(make_instr(OP_PUSH, 0, 0, 0, 32'h1234_5678, 0));
      pending_instrs.push_back(make_instr(OP_PUSH, 0, 2, 0, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_PUSH, 0, 3, 0, 32'hA5A5_5A5A, 0));
      pending_instrs.push_back(make_instr(OP_PUSH, 0, 1, 0, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_PUSH, 0, 1, 0, 32'd0, 1));
      pending_instrs.push_back(make_instr(OP_POP_REG, 31, 0, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_POP_VAL, 0, 0, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_POP_REG, 20, 0, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_POP_REG, 21, 0, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(OP_POP_VAL, 0, 0, 0, 32'd0, 0));
      pending_instrs.push_back(make_instr(4'd13, 1, 2, 3, 32'hFFFF_FFFF, 1));
      pending_instrs.push_back(make_instr(4'd15, 31, 31, 31, 32'd0, 0));
      wait_drained();

      write_stack_base(4096);
      queue_random(450);
      wait_drained();

      // Smallest stack base; receiver stalls long while the sender keeps going.
      write_stack_base(4);
      no_idle = 1'b1;
      queue_random(150);
      repeat (20) @(posedge clock);
      long_hold_req = 400;
      wait_drained();
      no_idle = 1'b0;

      write_stack_base($urandom_range(4, 4096));
      queue_random(400);
      wait_drained();

      write_stack_base(64);
      no_idle = 1'b1;
      queue_random(200);
      wait_drained();
      no_idle = 1'b0;

      write_stack_base(4093);
      queue_random(200);
      wait_drained();

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: toy_cpu_execute_unit_core.f
+incdir+sv
sv/tceu_pkg.sv
sv/tceu_if.sv
sv/tceu_ram.sv
sv/tceu_divider.sv
sv/toy_cpu_execute_unit_core.sv
sv/tceu_checker.sv
tb/toy_cpu_execute_unit_core_tb.sv
